// ----- design/fixed_point_alu_defines.svh -----
// ----------------------------------------------------------------------------
// fixed_point_alu assertion macros
// shared assertion forms for the fixed-point alu checkers
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// property must hold at every clock edge out of reset
`define FPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fixed_point_alu assertion failed");

// expression must never be true out of reset
`define FPA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("fixed_point_alu forbidden condition seen");

`endif

// ----- design/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// types, constants and the divider step for the fixed-point alu
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DIV_W         = DATA_W + FRACTION_BITS;
  localparam int unsigned NUM_STAGES    = DIV_W;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  typedef struct packed {
    op_e                mode;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic               neg;
    logic [DATA_W-1:0]  den;
    logic [DATA_W-1:0]  rem;
    logic [DIV_W-1:0]   num;
  } stage_t;

  // one restoring division bit: num shifts out dividend bits, in quotient bits
  function automatic stage_t div_step(stage_t s);
    stage_t         r;
    logic [DATA_W:0] trial_in;
    logic [DATA_W:0] diff;
    r        = s;
    trial_in = {s.rem, s.num[DIV_W-1]};
    diff     = trial_in - {1'b0, s.den};
    if (!diff[DATA_W]) begin
      r.rem = diff[DATA_W-1:0];
      r.num = {s.num[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = trial_in[DATA_W-1:0];
      r.num = {s.num[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu
// pipelined q24.8 fixed-point alu with bit-per-stage divider
// ----------------------------------------------------------------------------
// usage:
//   a request enters on valid_i with mode_i, operand_a_i and operand_b_i and
//   is taken when valid_i is high and stall_o is low. one result leaves on
//   valid_o with result_value_o, compare_true_o and divide_by_zero_o and is
//   taken when valid_o is high and stall_i is low.
//   the pipe is one input stage, one restoring divider stage per dividend
//   bit and one output register. the multiply uses one registered 32x32
//   product beside the last divider stage.
//   all modes share the same pipe, so results leave in request order.
//   throughput is one request per cycle while the receiver takes results.
//   when a result waits under stall_i the whole pipe holds and stall_o rises;
//   nothing is lost or repeated. reset clears all valid bits, so requests
//   still in the pipe are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu import fpa_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          stall_o,
  input  wire logic [3:0]               mode_i,
  input  wire logic signed [DATA_W-1:0] operand_a_i,
  input  wire logic signed [DATA_W-1:0] operand_b_i,
  output logic                          valid_o,
  input  wire logic                     stall_i,
  output logic signed [DATA_W-1:0]      result_value_o,
  output logic                          compare_true_o,
  output logic                          divide_by_zero_o
);

  logic                        adv;
  logic [NUM_STAGES:0]         vld_q;
  stage_t                      pipe_q [NUM_STAGES+1];
  stage_t                      in_d;
  logic signed [2*DATA_W-1:0]  prod_q;
  logic [DATA_W-1:0]           mag_a;
  logic [DATA_W-1:0]           mag_b;
  logic                        out_vld_q;
  logic [DATA_W-1:0]           res_d, res_q;
  logic                        cmp_d, cmp_q;
  logic                        dz_d, dz_q;
  stage_t                      fin;
  logic signed [DATA_W-1:0]    fa, fb;
  logic [DATA_W-1:0]           quo;

  assign adv     = !(out_vld_q && stall_i);
  assign stall_o = !adv;

  always_comb begin
    mag_a      = operand_a_i[DATA_W-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    mag_b      = operand_b_i[DATA_W-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    in_d.mode  = op_e'(mode_i);
    in_d.a     = operand_a_i;
    in_d.b     = operand_b_i;
    in_d.neg   = operand_a_i[DATA_W-1] ^ operand_b_i[DATA_W-1];
    in_d.den   = mag_b;
    in_d.rem   = '0;
    in_d.num   = {mag_a, {FRACTION_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= in_d;
      for (int s = 1; s <= NUM_STAGES; s++) begin
        pipe_q[s] <= div_step(pipe_q[s-1]);
      end
      prod_q <= $signed(pipe_q[NUM_STAGES-1].a) * $signed(pipe_q[NUM_STAGES-1].b);
    end
  end

  always_comb begin
    fin   = pipe_q[NUM_STAGES];
    fa    = $signed(fin.a);
    fb    = $signed(fin.b);
    quo   = fin.neg ? (~fin.num[DATA_W-1:0] + 1'b1) : fin.num[DATA_W-1:0];
    res_d = '0;
    cmp_d = 1'b0;
    dz_d  = 1'b0;
    case (fin.mode)
      OP_ADD:      res_d = fin.a + fin.b;
      OP_SUB:      res_d = fin.a - fin.b;
      OP_MUL:      res_d = prod_q[FRACTION_BITS+DATA_W-1:FRACTION_BITS];
      OP_DIV: begin
        if (fin.b == '0) begin
          dz_d = 1'b1;
        end else begin
          res_d = quo;
        end
      end
      OP_GT:       cmp_d = fa > fb;
      OP_LT:       cmp_d = fa < fb;
      OP_GE:       cmp_d = fa >= fb;
      OP_LE:       cmp_d = fa <= fb;
      OP_EQ:       cmp_d = fa == fb;
      OP_NE:       cmp_d = fa != fb;
      OP_MIN:      res_d = (fa > fb) ? fin.b : fin.a;
      OP_MAX:      res_d = (fa > fb) ? fin.a : fin.b;
      OP_INC:      res_d = fin.a + 1'b1;
      OP_DEC:      res_d = fin.a - 1'b1;
      OP_FROM_INT: res_d = fin.a << FRACTION_BITS;
      OP_TO_INT:   res_d = DATA_W'(fa >>> FRACTION_BITS);
      default:     res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NUM_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      cmp_q <= cmp_d;
      dz_q  <= dz_d;
    end
  end

  assign valid_o          = out_vld_q;
  assign result_value_o   = $signed(res_q);
  assign compare_true_o   = cmp_q;
  assign divide_by_zero_o = dz_q;

endmodule

`default_nettype wire

// ----- design/fpa_checker.sv -----
// ----------------------------------------------------------------------------
// fpa_checker
// port-level checks for the fixed-point alu, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_point_alu_defines.svh"

module fpa_checker import fpa_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     valid_i,
  input wire logic                     stall_o,
  input wire logic                     valid_o,
  input wire logic                     stall_i,
  input wire logic signed [DATA_W-1:0] result_value_o,
  input wire logic                     compare_true_o,
  input wire logic                     divide_by_zero_o
);

  `FPA_ASSERT(a_out_hold, clk_i, rst_ni, (valid_o && stall_i) |=> (valid_o && $stable(result_value_o)))
  `FPA_ASSERT(a_dz_zero, clk_i, rst_ni, (valid_o && divide_by_zero_o) |-> (result_value_o == '0))
  `FPA_ASSERT(a_cmp_zero, clk_i, rst_ni, (valid_o && compare_true_o) |-> (result_value_o == '0))
  `FPA_ASSERT_NEVER(a_flags_excl, clk_i, rst_ni, valid_o && compare_true_o && divide_by_zero_o)
  `FPA_ASSERT(a_stall_cause, clk_i, rst_ni, stall_o |-> (valid_o && stall_i))

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (valid_i),
  .stall_o          (stall_o),
  .valid_o          (valid_o),
  .stall_i          (stall_i),
  .result_value_o   (result_value_o),
  .compare_true_o   (compare_true_o),
  .divide_by_zero_o (divide_by_zero_o)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// regression for the fixed-point alu: directed corner requests for every mode,
// then random requests with random gaps and receiver stalls, a long receiver
// hold-off and a full drain; results are checked in order against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import fpa_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_res_t;

  function automatic alu_res_t alu_predict(op_e op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    r = '0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = 32'(prod >>> FRACTION_BITS);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = 64'(a) <<< FRACTION_BITS;
          quo = num / 64'(b);
          r.value = quo[31:0];
        end
      end
      OP_GT: r.cmp = a > b;
      OP_LT: r.cmp = a < b;
      OP_GE: r.cmp = a >= b;
      OP_LE: r.cmp = a <= b;
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.value = (a > b) ? b : a;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: r.value = a + 1;
      OP_DEC: r.value = a - 1;
      OP_FROM_INT: r.value = a <<< FRACTION_BITS;
      default: r.value = a >>> FRACTION_BITS;
    endcase
    return r;
  endfunction

  class alu_scoreboard;
    alu_res_t pending_q[$];
    int       errors;

    function void note_request(op_e op, logic signed [31:0] a, logic signed [31:0] b);
      pending_q.push_back(alu_predict(op, a, b));
    endfunction

    function void check_result(alu_res_t got);
      alu_res_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with no request pending: value %0d", got.value);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.value !== exp_r.value) begin
        $error("result_value exp %0d got %0d", exp_r.value, got.value);
        errors++;
      end
      if (got.cmp !== exp_r.cmp) begin
        $error("compare_true exp %0b got %0b", exp_r.cmp, got.cmp);
        errors++;
      end
      if (got.dz !== exp_r.dz) begin
        $error("divide_by_zero exp %0b got %0b", exp_r.dz, got.dz);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [3:0] mode_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic stall_o, valid_o, compare_true_o, divide_by_zero_o;
  logic signed [31:0] result_value_o;

  alu_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  localparam int WATCHDOG = 20000;

  always #2 clk_i = ~clk_i;

  fixed_point_alu i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .mode_i, .operand_a_i, .operand_b_i,
    .valid_o, .stall_i, .result_value_o, .compare_true_o, .divide_by_zero_o
  );

  // accepted requests and results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) sb.note_request(op_e'(mode_i), operand_a_i, operand_b_i);
      if (valid_o && !stall_i)
        sb.check_result('{result_value_o, compare_true_o, divide_by_zero_o});
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("fixed_point_alu regression: fail");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    stall_i <= hold_off || (!no_idle && $urandom_range(99) < 22);
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(2047)) - 1024);
      3: return $urandom_range(3) == 0 ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(op_e op, logic [31:0] a, logic [31:0] b);
    while (!no_idle && $urandom_range(99) < 22) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    mode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] a, b;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int m = 0; m < 16; m++) send(op_e'(m), 32'h7fff_ffff, 32'h8000_0000);
    send(OP_DIV, 32'h0000_0100, 32'h0);
    send(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    send(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
    send(OP_EQ, 32'h0000_1234, 32'h0000_1234);
    send(OP_INC, 32'h7fff_ffff, 32'h0);
    send(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
    send(OP_TO_INT, 32'hffff_ff01, 32'h0);
    drain();

    for (int i = 0; i < 1700; i++) begin
      if (i == 300) no_idle = 1'b1;
      if (i == 500) no_idle = 1'b0;
      if (i == 800) begin
        drain();
        repeat ($urandom_range(20, 5)) @(posedge clk_i);
      end
      if (i == 1000) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (150) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      a = rand_operand();
      b = $urandom_range(3) == 0 ? a : rand_operand();
      if ($urandom_range(9) == 0) b = 32'h0;
      send(op_e'($urandom_range(15)), a, b);
    end
    drain();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("fixed_point_alu regression: pass");
    end else begin
      $display("fixed_point_alu regression: fail");
    end
    $finish;
  end
endmodule

// ----- fixed_point_alu.f -----
+incdir+design
design/fpa_pkg.sv
design/fixed_point_alu.sv
design/fpa_checker.sv
tb/tb_top.sv
